// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the cover-crop scaler.
// Clock and reset are taken from the including scope (clock, reset).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/ccns_pkg.sv
// Shared types and constants of the cover-crop nearest scaler.
// No dependencies; used by the channel interfaces and the top level.
package ccns_pkg;

   localparam int unsigned MAX_DIM_DEF = 1024;
   localparam int unsigned COL_W       = 10;   // request and source index fields
   localparam int unsigned SIZE_W      = 11;   // size and edge registers
   localparam int unsigned POS_W       = 12;   // absolute destination position
   localparam int unsigned FRAC_W      = 16;   // fraction bits; the step is 11.16 fixed point
   localparam int unsigned STEP_W      = SIZE_W + FRAC_W;

   typedef enum logic [2:0] {
      CSR_SOURCE_WIDTH   = 3'd0,
      CSR_SOURCE_HEIGHT  = 3'd1,
      CSR_RECT_LEFT      = 3'd2,
      CSR_RECT_TOP       = 3'd3,
      CSR_RECT_WIDTH     = 3'd4,
      CSR_RECT_HEIGHT    = 3'd5,
      CSR_SURFACE_WIDTH  = 3'd6,
      CSR_SURFACE_HEIGHT = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      DRV_IDLE,
      DRV_LOAD,
      DRV_DIV,
      DRV_MIN,
      DRV_MUL,
      DRV_SUB
   } drv_state_type;

endpackage

// File: rtl/core/ccns_req_if.sv
// Request channel of the cover-crop scaler: one destination pixel position.
// Depends on ccns_pkg for field widths.
interface ccns_req_if;
   logic                         valid;
   logic                         ready;
   logic [ccns_pkg::COL_W-1:0]   out_col;
   logic [ccns_pkg::COL_W-1:0]   out_row;

   modport source (output valid, output out_col, output out_row, input ready);
   modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

// File: rtl/core/ccns_rsp_if.sv
// Response channel of the cover-crop scaler: source index, position, visibility.
// Depends on ccns_pkg for field widths.
interface ccns_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ccns_pkg::COL_W-1:0]          src_col;
   logic [ccns_pkg::COL_W-1:0]          src_row;
   logic signed [ccns_pkg::POS_W-1:0]   dest_x;
   logic signed [ccns_pkg::POS_W-1:0]   dest_y;
   logic                                visible;

   modport source (output valid, output src_col, output src_row, output dest_x,
                   output dest_y, output visible, input ready);
   modport sink   (input valid, input src_col, input src_row, input dest_x,
                   input dest_y, input visible, output ready);
endinterface

// File: rtl/core/cover_crop_nearest_scaler.sv
// Cover-crop nearest-neighbour scaler: maps rectangle pixels to source pixels.
// Depends on ccns_pkg, ccns_req_if, ccns_rsp_if and assert_macros.svh.

`include "assert_macros.svh"

// Takes one request per clock while no derivation runs and the response side
// is not stalled; a request passes the input, multiply, crop add and
// clamp/output register stages; a stalled response holds the pipeline without
// losing anything. Each CSR write starts a re-derivation of the shared 11.16
// step and the two crop offsets: a load state, a one-bit-per-cycle restoring
// divider (both axes in parallel), then min, multiply and subtract. req ready
// stays low during that time; CSR writes are taken at any time and restart it.
module cover_crop_nearest_scaler #(
   parameter int unsigned MAX_DIM = ccns_pkg::MAX_DIM_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   ccns_req_if.sink                      req_chan,
   ccns_rsp_if.source                    rsp_chan,
   input  logic                          csr_write,
   input  ccns_pkg::csr_index_type       csr_index,
   input  logic [ccns_pkg::SIZE_W-1:0]   csr_data
);
   import ccns_pkg::*;

   localparam int unsigned PROD_W   = STEP_W + COL_W;
   localparam int unsigned SUM_W    = PROD_W + 1;
   localparam int unsigned IDX_W    = SUM_W - FRAC_W;
   localparam int unsigned MUL_W    = STEP_W + SIZE_W;
   localparam int unsigned CNT_W    = $clog2(STEP_W);
   localparam int unsigned COL_MAX  = (1 << COL_W) - 1;
   localparam logic [COL_W-1:0] LIM_CAP =
      COL_W'((MAX_DIM - 1 < COL_MAX) ? MAX_DIM - 1 : COL_MAX);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(STEP_W - 1);

   function automatic logic [SIZE_W-1:0] sat_dim(input logic [SIZE_W-1:0] v);
      if (32'(v) > MAX_DIM) begin
         return SIZE_W'(MAX_DIM);
      end
      return v;
   endfunction

   // ---------------------------------------------------------------- CSRs
   logic [SIZE_W-1:0]        src_w_ff, src_h_ff, rect_w_ff, rect_h_ff;
   logic [SIZE_W-1:0]        surf_w_ff, surf_h_ff;
   logic signed [SIZE_W-1:0] rect_l_ff, rect_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff  <= '0;
         src_h_ff  <= '0;
         rect_w_ff <= '0;
         rect_h_ff <= '0;
         surf_w_ff <= '0;
         surf_h_ff <= '0;
         rect_l_ff <= '0;
         rect_t_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:   src_w_ff  <= sat_dim(csr_data);
            CSR_SOURCE_HEIGHT:  src_h_ff  <= sat_dim(csr_data);
            CSR_RECT_LEFT:      rect_l_ff <= $signed(csr_data);
            CSR_RECT_TOP:       rect_t_ff <= $signed(csr_data);
            CSR_RECT_WIDTH:     rect_w_ff <= sat_dim(csr_data);
            CSR_RECT_HEIGHT:    rect_h_ff <= sat_dim(csr_data);
            CSR_SURFACE_WIDTH:  surf_w_ff <= sat_dim(csr_data);
            CSR_SURFACE_HEIGHT: surf_h_ff <= sat_dim(csr_data);
            default: ;
         endcase
      end
   end

   logic sizes_ok;
   assign sizes_ok = (src_w_ff != '0) && (src_h_ff != '0) &&
                     (rect_w_ff != '0) && (rect_h_ff != '0);

   // ---------------------------------------------------------- derivation
   drv_state_type drv_state_ff, drv_state_in;
   logic load_en, div_en, min_en, mul_en, sub_en, busy;

   logic [CNT_W-1:0]  cnt_ff;
   logic [SIZE_W-1:0] remx_ff, remy_ff;
   logic [STEP_W-1:0] quox_ff, quoy_ff;
   logic [STEP_W-1:0] step_ff;
   logic [MUL_W-1:0]  prodx_ff, prody_ff;
   logic [STEP_W-1:0] cropx_ff, cropy_ff;

   logic [STEP_W-1:0] numx, numy;
   logic [SIZE_W:0]   shx, shy;
   logic              gex, gey;

   assign numx = {src_w_ff, FRAC_W'(0)};
   assign numy = {src_h_ff, FRAC_W'(0)};

   // restoring divider, one quotient bit per cycle per axis
   assign shx = {remx_ff, quox_ff[STEP_W-1]};
   assign shy = {remy_ff, quoy_ff[STEP_W-1]};
   assign gex = shx >= {1'b0, rect_w_ff};
   assign gey = shy >= {1'b0, rect_h_ff};

   always_comb begin
      drv_state_in = drv_state_ff;
      unique case (drv_state_ff)
         DRV_IDLE: drv_state_in = DRV_IDLE;
         DRV_LOAD: drv_state_in = DRV_DIV;
         DRV_DIV:  drv_state_in = (cnt_ff == DIV_LAST) ? DRV_MIN : DRV_DIV;
         DRV_MIN:  drv_state_in = DRV_MUL;
         DRV_MUL:  drv_state_in = DRV_SUB;
         DRV_SUB:  drv_state_in = DRV_IDLE;
         default:  drv_state_in = DRV_IDLE;
      endcase
      // any write restarts the derivation from the current registers
      if (csr_write) begin
         drv_state_in = DRV_LOAD;
      end
   end

   always_comb begin
      load_en = 1'b0;
      div_en  = 1'b0;
      min_en  = 1'b0;
      mul_en  = 1'b0;
      sub_en  = 1'b0;
      busy    = 1'b1;
      unique case (drv_state_ff)
         DRV_IDLE: busy    = 1'b0;
         DRV_LOAD: load_en = 1'b1;
         DRV_DIV:  div_en  = 1'b1;
         DRV_MIN:  min_en  = 1'b1;
         DRV_MUL:  mul_en  = 1'b1;
         DRV_SUB:  sub_en  = 1'b1;
         default:  busy    = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drv_state_ff <= DRV_IDLE;
      end else begin
         drv_state_ff <= drv_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         quox_ff <= numx;
         quoy_ff <= numy;
         remx_ff <= '0;
         remy_ff <= '0;
         cnt_ff  <= '0;
      end
      if (div_en) begin
         remx_ff <= gex ? SIZE_W'(shx - {1'b0, rect_w_ff}) : shx[SIZE_W-1:0];
         remy_ff <= gey ? SIZE_W'(shy - {1'b0, rect_h_ff}) : shy[SIZE_W-1:0];
         quox_ff <= {quox_ff[STEP_W-2:0], gex};
         quoy_ff <= {quoy_ff[STEP_W-2:0], gey};
         cnt_ff  <= cnt_ff + 1'b1;
      end
      if (min_en) begin
         step_ff <= (quox_ff < quoy_ff) ? quox_ff : quoy_ff;
      end
      if (mul_en) begin
         prodx_ff <= MUL_W'(step_ff) * MUL_W'(rect_w_ff);
         prody_ff <= MUL_W'(step_ff) * MUL_W'(rect_h_ff);
      end
      if (sub_en) begin
         // step never exceeds either quotient, so the difference is not negative
         cropx_ff <= STEP_W'((MUL_W'(numx) - prodx_ff) >> 1);
         cropy_ff <= STEP_W'((MUL_W'(numy) - prody_ff) >> 1);
      end
   end

   // ------------------------------------------------------------ pipeline
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4, req_fire;

   assign adv4     = !v4_ff || rsp_chan.ready;
   assign adv3     = !v3_ff || adv4;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign req_chan.ready = adv1 && !busy;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_fire;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // stage 1: capture request, destination position, inside-rectangle test
   logic [COL_W-1:0]        col1_ff, row1_ff;
   logic signed [POS_W-1:0] dx1_ff, dy1_ff;
   logic                    inrect1_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         col1_ff    <= req_chan.out_col;
         row1_ff    <= req_chan.out_row;
         dx1_ff     <= POS_W'(rect_l_ff) + $signed({2'b00, req_chan.out_col});
         dy1_ff     <= POS_W'(rect_t_ff) + $signed({2'b00, req_chan.out_row});
         inrect1_ff <= ({1'b0, req_chan.out_col} < rect_w_ff) &&
                       ({1'b0, req_chan.out_row} < rect_h_ff);
      end
   end

   // stage 2: step times index, surface clip
   logic [PROD_W-1:0]       px2_ff, py2_ff;
   logic signed [POS_W-1:0] dx2_ff, dy2_ff;
   logic                    vis2_ff, ok2_ff;
   logic                    on_surf;

   assign on_surf = !dx1_ff[POS_W-1] && (dx1_ff[SIZE_W-1:0] < surf_w_ff) &&
                    !dy1_ff[POS_W-1] && (dy1_ff[SIZE_W-1:0] < surf_h_ff);

   always_ff @(posedge clock) begin
      if (adv2) begin
         px2_ff  <= PROD_W'(step_ff) * PROD_W'(col1_ff);
         py2_ff  <= PROD_W'(step_ff) * PROD_W'(row1_ff);
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         ok2_ff  <= sizes_ok;
         vis2_ff <= sizes_ok && inrect1_ff && on_surf;
      end
   end

   // stage 3: add crop offset, keep the integer part
   logic [SUM_W-1:0]        sumx, sumy;
   logic [IDX_W-1:0]        ix3_ff, iy3_ff;
   logic signed [POS_W-1:0] dx3_ff, dy3_ff;
   logic                    vis3_ff, ok3_ff;

   assign sumx = SUM_W'(cropx_ff) + SUM_W'(px2_ff);
   assign sumy = SUM_W'(cropy_ff) + SUM_W'(py2_ff);

   always_ff @(posedge clock) begin
      if (adv3) begin
         ix3_ff  <= sumx[SUM_W-1:FRAC_W];
         iy3_ff  <= sumy[SUM_W-1:FRAC_W];
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         ok3_ff  <= ok2_ff;
         vis3_ff <= vis2_ff;
      end
   end

   // stage 4: clamp to the picture and hold the response
   logic [SIZE_W-1:0]       wm1, hm1;
   logic [COL_W-1:0]        limx, limy, cx, cy;
   logic [COL_W-1:0]        sc4_ff, sr4_ff;
   logic signed [POS_W-1:0] dx4_ff, dy4_ff;
   logic                    vis4_ff, ok4_ff;

   assign wm1  = src_w_ff - 1'b1;
   assign hm1  = src_h_ff - 1'b1;
   assign limx = (wm1 > SIZE_W'(LIM_CAP)) ? LIM_CAP : wm1[COL_W-1:0];
   assign limy = (hm1 > SIZE_W'(LIM_CAP)) ? LIM_CAP : hm1[COL_W-1:0];
   assign cx   = (ix3_ff > IDX_W'(limx)) ? limx : ix3_ff[COL_W-1:0];
   assign cy   = (iy3_ff > IDX_W'(limy)) ? limy : iy3_ff[COL_W-1:0];

   always_ff @(posedge clock) begin
      if (adv4) begin
         sc4_ff  <= ok3_ff ? cx : '0;
         sr4_ff  <= ok3_ff ? cy : '0;
         dx4_ff  <= dx3_ff;
         dy4_ff  <= dy3_ff;
         ok4_ff  <= ok3_ff;
         vis4_ff <= vis3_ff;
      end
   end

   assign rsp_chan.valid   = v4_ff;
   assign rsp_chan.src_col = sc4_ff;
   assign rsp_chan.src_row = sr4_ff;
   assign rsp_chan.dest_x  = dx4_ff;
   assign rsp_chan.dest_y  = dy4_ff;
   assign rsp_chan.visible = vis4_ff;

   // ---------------------------------------------------------- assertions
   `ASSERT_IMPL(a_no_req_while_deriving, drv_state_ff != DRV_IDLE, !req_chan.ready)
   `ASSERT_IMPL(a_div_count_bound, drv_state_ff == DRV_DIV, cnt_ff <= DIV_LAST)
   `ASSERT_NEXT(a_stage3_moves_out, v3_ff && adv4, v4_ff)
   `ASSERT_IMPL(a_zero_size_hidden, v4_ff && !ok4_ff,
                !vis4_ff && sc4_ff == '0 && sr4_ff == '0)

endmodule

// File: tb/ccns_map_checker.sv
`timescale 1ns / 1ps
// Checker for the cover-crop nearest scaler: tracks the geometry registers,
// predicts the pixel mapping of every request and compares responses in order.
// Depends on ccns_pkg and the ccns_req_if / ccns_rsp_if channel interfaces.
module ccns_map_checker (
   input  logic                          clock,
   input  logic                          reset,
   ccns_req_if                           req_mon,
   ccns_rsp_if                           rsp_mon,
   input  logic                          csr_write,
   input  ccns_pkg::csr_index_type       csr_index,
   input  logic [ccns_pkg::SIZE_W-1:0]   csr_data,
   output int                            mismatch_count,
   output int                            pending_results
);
   import ccns_pkg::*;

   localparam logic [SIZE_W-1:0] DIM_LIMIT = SIZE_W'(MAX_DIM_DEF);
   localparam logic [63:0]       LAST_INDEX = 64'd1023;

   typedef struct packed {
      logic [COL_W-1:0]        src_col;
      logic [COL_W-1:0]        src_row;
      logic signed [POS_W-1:0] dest_x;
      logic signed [POS_W-1:0] dest_y;
      logic                    visible;
   } pixel_map_type;

   logic [SIZE_W-1:0]        source_w, source_h, rect_w, rect_h, surface_w, surface_h;
   logic signed [SIZE_W-1:0] left_edge, top_edge;
   logic [31:0]              step_q16, crop_x_q16, crop_y_q16;
   pixel_map_type            expected_maps[$];

   function automatic logic [SIZE_W-1:0] saturate_size(logic [SIZE_W-1:0] v);
      return (v > DIM_LIMIT) ? DIM_LIMIT : v;
   endfunction

   function automatic logic geometry_valid();
      return (source_w != 0) && (source_h != 0) && (rect_w != 0) && (rect_h != 0);
   endfunction

   // integer part of crop + step * idx, clamped to the picture and the field
   function automatic logic [COL_W-1:0] source_index(logic [31:0] crop,
                                                     logic [COL_W-1:0] idx,
                                                     logic [SIZE_W-1:0] size);
      logic [63:0] whole;
      logic [63:0] last;
      whole = ({32'd0, crop} + {32'd0, step_q16} * {54'd0, idx}) >> FRAC_W;
      last  = {53'd0, size} - 64'd1;
      if (last > LAST_INDEX) last = LAST_INDEX;
      if (whole > last) whole = last;
      return whole[COL_W-1:0];
   endfunction

   always @(posedge clock) begin
      pixel_map_type want, got;
      logic [63:0]   span_x, span_y, ratio_x, ratio_y, ratio;
      int            dx, dy;
      if (reset) begin
         source_w  = '0;
         source_h  = '0;
         rect_w    = '0;
         rect_h    = '0;
         surface_w = '0;
         surface_h = '0;
         left_edge = '0;
         top_edge  = '0;
         step_q16  = '0;
         crop_x_q16 = '0;
         crop_y_q16 = '0;
         expected_maps.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SOURCE_WIDTH:   source_w  = saturate_size(csr_data);
               CSR_SOURCE_HEIGHT:  source_h  = saturate_size(csr_data);
               CSR_RECT_LEFT:      left_edge = csr_data;
               CSR_RECT_TOP:       top_edge  = csr_data;
               CSR_RECT_WIDTH:     rect_w    = saturate_size(csr_data);
               CSR_RECT_HEIGHT:    rect_h    = saturate_size(csr_data);
               CSR_SURFACE_WIDTH:  surface_w = saturate_size(csr_data);
               CSR_SURFACE_HEIGHT: surface_h = saturate_size(csr_data);
               default: ;
            endcase
            // shared step is the smaller axis ratio; crop the overflow evenly
            if (geometry_valid()) begin
               span_x  = {53'd0, source_w} << FRAC_W;
               span_y  = {53'd0, source_h} << FRAC_W;
               ratio_x = span_x / {53'd0, rect_w};
               ratio_y = span_y / {53'd0, rect_h};
               ratio   = (ratio_x < ratio_y) ? ratio_x : ratio_y;
               step_q16   = ratio[31:0];
               span_x     = (span_x - ratio * {53'd0, rect_w}) >> 1;
               span_y     = (span_y - ratio * {53'd0, rect_h}) >> 1;
               crop_x_q16 = span_x[31:0];
               crop_y_q16 = span_y[31:0];
            end else begin
               step_q16   = '0;
               crop_x_q16 = '0;
               crop_y_q16 = '0;
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            dx = int'(left_edge) + int'(req_mon.out_col);
            dy = int'(top_edge) + int'(req_mon.out_row);
            want.dest_x  = dx[POS_W-1:0];
            want.dest_y  = dy[POS_W-1:0];
            want.src_col = '0;
            want.src_row = '0;
            want.visible = 1'b0;
            if (geometry_valid()) begin
               want.src_col = source_index(crop_x_q16, req_mon.out_col, source_w);
               want.src_row = source_index(crop_y_q16, req_mon.out_row, source_h);
               want.visible = (req_mon.out_col < rect_w) && (req_mon.out_row < rect_h) &&
                              (dx >= 0) && (dx < int'(surface_w)) &&
                              (dy >= 0) && (dy < int'(surface_h));
            end
            expected_maps.push_back(want);
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.src_col = rsp_mon.src_col;
            got.src_row = rsp_mon.src_row;
            got.dest_x  = rsp_mon.dest_x;
            got.dest_y  = rsp_mon.dest_y;
            got.visible = rsp_mon.visible;
            if (expected_maps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] unexpected response: col %0d row %0d x %0d y %0d vis %0b",
                           $time, got.src_col, got.src_row, got.dest_x, got.dest_y,
                           got.visible);
            end else begin
               want = expected_maps.pop_front();
               if (got.src_col !== want.src_col || got.src_row !== want.src_row ||
                   got.dest_x !== want.dest_x || got.dest_y !== want.dest_y ||
                   got.visible !== want.visible) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("[%0t] mismatch: expected col,row,x,y,vis %0d,%0d,%0d,%0d,%0b",
                              $time, want.src_col, want.src_row, want.dest_x,
                              want.dest_y, want.visible);
                     $display("[%0t]           got      col,row,x,y,vis %0d,%0d,%0d,%0d,%0b",
                              $time, got.src_col, got.src_row, got.dest_x,
                              got.dest_y, got.visible);
                  end
               end
            end
         end
      end
      pending_results <= expected_maps.size();
   end

endmodule

// File: tb/cover_crop_nearest_scaler_tb.sv
`timescale 1ns / 1ps
// Top of the cover-crop nearest scaler testbench: clock, reset, geometry
// writes, pixel requests and response back-pressure; checking sits in
// ccns_map_checker. Depends on ccns_pkg, the channel interfaces and the RTL.
module cover_crop_nearest_scaler_tb;
   import ccns_pkg::*;

   localparam int unsigned RANDOM_PHASES    = 15;
   localparam int unsigned PIXELS_PER_PHASE = 125;
   localparam int unsigned HOLD_OFF_CYCLES  = 80;
   localparam int unsigned DRAIN_CYCLES     = 12;
   localparam int unsigned IDLE_LIMIT       = 3000;
   localparam logic [SIZE_W-1:0] DIM_LIMIT  = SIZE_W'(MAX_DIM_DEF);

   typedef logic [7:0][SIZE_W-1:0] geometry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write = 1'b0;
   csr_index_type     csr_index = CSR_SOURCE_WIDTH;
   logic [SIZE_W-1:0] csr_data = '0;
   int                mismatch_count;
   int                pending_results;
   int                idle_cycles = 0;
   bit                no_gaps = 1'b0;
   bit                hold_off_request = 1'b0;

   ccns_req_if req_chan();
   ccns_rsp_if rsp_chan();

   always #1 clock = ~clock;

   cover_crop_nearest_scaler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ccns_map_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // index i of the packed array is register index i
   function automatic geometry_type make_geometry(int sw, int sh, int lx, int ty,
                                                  int rw, int rh, int fw, int fh);
      return {SIZE_W'(fh), SIZE_W'(fw), SIZE_W'(rh), SIZE_W'(rw),
              SIZE_W'(ty), SIZE_W'(lx), SIZE_W'(sh), SIZE_W'(sw)};
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 6) return '0;
      if (roll < 14) return SIZE_W'($urandom_range(1025, 2047));
      if (roll < 30) return SIZE_W'($urandom_range(1, 16));
      return SIZE_W'($urandom_range(1, 1024));
   endfunction

   // mostly inside the rectangle, the rest anywhere in the field
   function automatic logic [COL_W-1:0] pick_coord(logic [SIZE_W-1:0] extent);
      logic [SIZE_W-1:0] span;
      span = (extent > DIM_LIMIT) ? DIM_LIMIT : extent;
      if (span != 0 && $urandom_range(0, 99) < 80)
         return COL_W'($urandom_range(0, span - 1));
      return COL_W'($urandom_range(0, 1023));
   endfunction

   task automatic load_geometry(geometry_type shape);
      for (int i = 0; i < 8; i++) begin
         csr_write <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= shape[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   task automatic send_pixel(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
      if (!no_gaps && $urandom_range(0, 99) < 21) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 21);
      end
      req_chan.valid   <= 1'b1;
      req_chan.out_col <= col;
      req_chan.out_row <= row;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // drop valid and hold until every request has its response
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // response back-pressure
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= no_gaps || ($urandom_range(0, 99) >= 21);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("cover_crop_nearest_scaler verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      geometry_type shape;
      req_chan.valid   <= 1'b0;
      req_chan.out_col <= '0;
      req_chan.out_row <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: every size is zero, nothing visible
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd5, 10'd7);
      wait_for_results();

      // wide picture into a square: horizontal crop, surface clips inside the rect
      load_geometry(make_geometry(640, 480, 10, 20, 320, 320, 300, 300));
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd319, 10'd279);
      send_pixel(10'd320, 10'd5);
      send_pixel(10'd5, 10'd320);
      send_pixel(10'd295, 10'd0);
      send_pixel(10'd0, 10'd285);
      send_pixel(10'd1023, 10'd1023);
      wait_for_results();

      // oversize writes saturate; most negative left edge, largest top edge
      load_geometry(make_geometry(2047, 1025, -1024, 1023, 2047, 1024, 2047, 2047));
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      wait_for_results();

      // single-pixel rectangle: any index past it clamps to the picture
      load_geometry(make_geometry(1, 1024, 0, 0, 1, 1, 1, 1));
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      wait_for_results();

      // large step: source index clamps at the field limit
      load_geometry(make_geometry(1024, 1024, 0, 0, 3, 2, 1024, 1024));
      send_pixel(10'd2, 10'd1);
      send_pixel(10'd1023, 10'd1023);
      wait_for_results();

      // one zero size blanks the whole mapping
      load_geometry(make_geometry(500, 0, 0, 0, 100, 100, 1024, 1024));
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd3, 10'd3);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         shape = make_geometry(pick_size(), pick_size(), $urandom_range(0, 2047),
                               $urandom_range(0, 2047), pick_size(), pick_size(),
                               pick_size(), pick_size());
         load_geometry(shape);
         no_gaps = (phase == 4);
         // receiver stalls while requests keep coming, so the pipeline backs up
         if (phase == 2) hold_off_request = 1'b1;
         for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
            if (phase == 6 && n == PIXELS_PER_PHASE / 2) wait_for_results();
            send_pixel(pick_coord(shape[CSR_RECT_WIDTH]), pick_coord(shape[CSR_RECT_HEIGHT]));
         end
      end
      no_gaps = 1'b0;

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("cover_crop_nearest_scaler verification clean");
      end else begin
         $display("cover_crop_nearest_scaler verification failed");
      end
      $finish;
   end

endmodule
